/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that is also checked across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/i2cme_pkg.sv */
// ---------------------------------------------------------------------------
// i2cme_pkg
// types and constants of the i2c master bit engine
// ---------------------------------------------------------------------------
`default_nettype none

package i2cme_pkg;

    // command codes
    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_NONE  = 3'd0;
    localparam t_cmd CMD_START = 3'd1;
    localparam t_cmd CMD_WRITE = 3'd2;
    localparam t_cmd CMD_READ  = 3'd3;
    localparam t_cmd CMD_STOP  = 3'd4;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DELAY_TICKS    = 1'b0;
    localparam t_cfg_idx CFG_ACK_POLL_LIMIT = 1'b1;

    localparam int unsigned W_CFG_DATA = 16;
    localparam logic [15:0] DELAY_TICKS_RST    = 16'd2;
    localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;

    localparam int unsigned W_S_TDATA = 16;
    localparam int unsigned W_M_TDATA = 16;

    // one tick item, last field in the lowest bits
    typedef struct packed {
        logic       sda_in;
        logic       send_ack;
        logic [7:0] tx_byte;
        t_cmd       command;
    } t_item;

    // one result item, last field in the lowest bits
    typedef struct packed {
        logic       nack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

`default_nettype wire

/* rtl/i2cme_seq.sv */
// ---------------------------------------------------------------------------
// i2cme_seq
// bus sequencer: advances one tick per accepted item and forms its result
// ---------------------------------------------------------------------------
`default_nettype none

module i2cme_seq (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire i2cme_pkg::t_item     i_item,
    input  wire                       i_cfg_we,
    input  wire i2cme_pkg::t_cfg_idx  i_cfg_idx,
    input  wire [i2cme_pkg::W_CFG_DATA-1:0] i_cfg_wdata,
    output i2cme_pkg::t_result        o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_START_SDA, S_START_SCL, S_FINISH,
        S_STOP_SCL, S_STOP_SDA, S_WR_HIGH, S_WR_LOW,
        S_ACK_HIGH, S_POLL, S_RD_SAMPLE, S_RD_HIGH,
        S_AK_SDA, S_AK_HIGH, S_AK_LOW, S_AK_RELEASE
    } t_step;

    t_step       r_step, n_step;
    logic [15:0] r_dcnt, n_dcnt;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_poll, n_poll;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_ack, n_ack;
    logic        r_nack, n_nack;
    logic [7:0]  r_rx, n_rx;
    logic [15:0] r_delay;
    logic [7:0]  r_limit;

    logic [15:0] w_hold;
    logic [3:0]  w_bits_inc;
    logic [7:0]  w_shift_wr;
    logic [7:0]  w_shift_rd;
    logic        w_done;

    // reload value of the hold counter, a zero delay acts as one
    assign w_hold     = (r_delay == 16'd0) ? 16'd0 : r_delay - 16'd1;
    assign w_bits_inc = r_bits + 4'd1;
    assign w_shift_wr = {r_shift[6:0], 1'b0};
    assign w_shift_rd = {r_shift[6:0], i_item.sda_in};

    // next state for one tick
    always_comb begin
        n_step  = r_step;
        n_dcnt  = r_dcnt;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_nack  = r_nack;
        n_rx    = r_rx;
        w_done  = 1'b0;
        if (r_step == S_IDLE) begin
            unique case (i_item.command)
                i2cme_pkg::CMD_START: begin
                    n_sda  = 1'b1;
                    n_scl  = 1'b1;
                    n_dcnt = w_hold;
                    n_step = S_START_SDA;
                end
                i2cme_pkg::CMD_WRITE: begin
                    n_shift = i_item.tx_byte;
                    n_bits  = 4'd0;
                    n_nack  = 1'b0;
                    n_sda   = i_item.tx_byte[7];
                    n_dcnt  = w_hold;
                    n_step  = S_WR_HIGH;
                end
                i2cme_pkg::CMD_READ: begin
                    n_shift = 8'd0;
                    n_bits  = 4'd0;
                    n_ack   = i_item.send_ack;
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                    n_dcnt  = w_hold;
                    n_step  = S_RD_SAMPLE;
                end
                i2cme_pkg::CMD_STOP: begin
                    n_sda  = 1'b0;
                    n_dcnt = w_hold;
                    n_step = S_STOP_SCL;
                end
                default: begin
                end
            endcase
        end else if (r_dcnt != 16'd0) begin
            n_dcnt = r_dcnt - 16'd1;
        end else begin
            n_dcnt = w_hold;
            unique case (r_step)
                S_START_SDA: begin
                    n_sda  = 1'b0;
                    n_step = S_START_SCL;
                end
                S_START_SCL: begin
                    n_scl  = 1'b0;
                    n_step = S_FINISH;
                end
                S_STOP_SCL: begin
                    n_scl  = 1'b1;
                    n_step = S_STOP_SDA;
                end
                S_STOP_SDA: begin
                    n_sda  = 1'b1;
                    n_step = S_FINISH;
                end
                S_WR_HIGH: begin
                    n_scl  = 1'b1;
                    n_step = S_WR_LOW;
                end
                S_WR_LOW: begin
                    n_scl   = 1'b0;
                    n_shift = w_shift_wr;
                    n_bits  = w_bits_inc;
                    if (w_bits_inc < 4'd8) begin
                        n_sda  = w_shift_wr[7];
                        n_step = S_WR_HIGH;
                    end else begin
                        n_sda  = 1'b1;
                        n_step = S_ACK_HIGH;
                    end
                end
                S_ACK_HIGH: begin
                    n_scl  = 1'b1;
                    n_poll = 8'd0;
                    n_step = S_POLL;
                end
                S_POLL: begin
                    // low sda is the ack; give up once the poll limit is used up
                    if (!i_item.sda_in) begin
                        n_scl  = 1'b0;
                        n_step = S_FINISH;
                    end else if (r_poll >= r_limit) begin
                        n_nack = 1'b1;
                        n_scl  = 1'b0;
                        n_step = S_FINISH;
                    end else begin
                        n_poll = r_poll + 8'd1;
                        n_step = S_POLL;
                    end
                end
                S_RD_SAMPLE: begin
                    n_shift = w_shift_rd;
                    n_scl   = 1'b0;
                    n_bits  = w_bits_inc;
                    if (w_bits_inc >= 4'd8) begin
                        n_rx   = w_shift_rd;
                        n_step = S_AK_SDA;
                    end else begin
                        n_step = S_RD_HIGH;
                    end
                end
                S_RD_HIGH: begin
                    n_scl  = 1'b1;
                    n_step = S_RD_SAMPLE;
                end
                S_AK_SDA: begin
                    n_sda  = !r_ack;
                    n_step = S_AK_HIGH;
                end
                S_AK_HIGH: begin
                    n_scl  = 1'b1;
                    n_step = S_AK_LOW;
                end
                S_AK_LOW: begin
                    n_scl  = 1'b0;
                    n_step = r_ack ? S_AK_RELEASE : S_FINISH;
                end
                S_AK_RELEASE: begin
                    n_sda  = 1'b1;
                    n_step = S_FINISH;
                end
                S_FINISH, S_IDLE: begin
                    // completion tick
                    n_step = S_IDLE;
                    n_dcnt = 16'd0;
                    w_done = 1'b1;
                end
            endcase
        end
    end

    // result of this tick
    always_comb begin
        o_res          = '0;
        o_res.scl_out  = n_scl;
        o_res.sda_out  = n_sda;
        o_res.busy_res = (n_step != S_IDLE);
        o_res.done_res = w_done;
        o_res.rx_byte  = n_rx;
        o_res.nack     = n_nack;
    end

    // state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_dcnt  <= 16'd0;
            r_bits  <= 4'd0;
            r_shift <= 8'd0;
            r_poll  <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_ack   <= 1'b0;
            r_nack  <= 1'b0;
            r_rx    <= 8'd0;
            r_delay <= i2cme_pkg::DELAY_TICKS_RST;
            r_limit <= i2cme_pkg::ACK_POLL_LIMIT_RST;
        end else begin
            if (i_en) begin
                r_step  <= n_step;
                r_dcnt  <= n_dcnt;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_poll  <= n_poll;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_ack   <= n_ack;
                r_nack  <= n_nack;
                r_rx    <= n_rx;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    i2cme_pkg::CFG_DELAY_TICKS:    r_delay <= i_cfg_wdata;
                    i2cme_pkg::CFG_ACK_POLL_LIMIT: r_limit <= i_cfg_wdata[7:0];
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_engine_unit.sv */
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// i2c master that drives scl and sda, one base tick per input transaction
// ---------------------------------------------------------------------------
// Usage:
//   Each input transaction on the s_ side is one base tick: an optional
//   command (start, write byte, read byte, stop), its byte and ack choice,
//   and the sampled sda level. Commands are taken only when the engine is
//   idle. Each tick yields exactly one output transaction on the m_ side
//   with the scl/sda levels to drive, busy and done flags, the last read
//   byte and the nack flag of the last write.
//   Results are registered; one tick is accepted per cycle while o_s_tready
//   is high, set by the single-pass sequencer update between registers.
//   The user writes configuration (hold ticks per pin change, ack poll limit)
//   through i_cfg_we/i_cfg_idx/i_cfg_wdata while no tick is in flight; the
//   engine does not enforce this. Reset returns the engine to idle with both
//   lines released, hold 2 ticks, poll limit 250 and the output side empty.
//   When the receiver stalls, one more result is held in a skid stage;
//   after that o_s_tready drops until the receiver takes a result.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // stream in: command[2:0], tx_byte[10:3], send_ack[11], sda_in[12]
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire [i2cme_pkg::W_S_TDATA-1:0]     i_s_tdata,
    // stream out: scl_out[0], sda_out[1], busy_res[2], done_res[3],
    // rx_byte[11:4], nack[12]
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [i2cme_pkg::W_M_TDATA-1:0]    o_m_tdata,
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire i2cme_pkg::t_cfg_idx           i_cfg_idx,
    input  wire [i2cme_pkg::W_CFG_DATA-1:0]    i_cfg_wdata
);

    localparam int unsigned PAD = i2cme_pkg::W_M_TDATA - $bits(i2cme_pkg::t_result);

    i2cme_pkg::t_item   w_item;
    i2cme_pkg::t_result w_res;
    i2cme_pkg::t_result r_main, r_skid;
    logic               r_main_valid, r_skid_valid;
    logic               w_accept, w_take;

    assign w_item   = i2cme_pkg::t_item'(i_s_tdata[$bits(i2cme_pkg::t_item)-1:0]);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_take   = r_main_valid && i_m_tready;

    i2cme_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_accept),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (w_res)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_take) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main       <= w_res;
                r_main_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid       <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_main_valid;
    assign o_m_tdata  = {{PAD{1'b0}}, r_main};

endmodule

`default_nettype wire

/* rtl/i2cme_checker.sv */
// ---------------------------------------------------------------------------
// i2cme_checker
// port-level checks of the i2c master bit engine, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cme_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_tvalid,
    input wire                             o_s_tready,
    input wire                             o_m_tvalid,
    input wire                             i_m_tready,
    input wire [i2cme_pkg::W_M_TDATA-1:0]  o_m_tdata
);

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // the completion tick never reports busy
    `ASSERT_CLK(a_done_not_busy, i_clk, i_rst_n, o_m_tvalid |-> !(o_m_tdata[3] && o_m_tdata[2]), "done and busy together")

    // an input taken into an empty output shows up in the next cycle
    `ASSERT_CLK(a_latency, i_clk, i_rst_n, i_s_tvalid && o_s_tready && !o_m_tvalid |=> o_m_tvalid, "result missing after one cycle")

    // backpressure only while a result is waiting
    `ASSERT_CLK(a_ready_low, i_clk, i_rst_n, !o_s_tready |-> o_m_tvalid, "input stalled with output empty")

    // reset empties the output side
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind i2c_master_bit_engine_unit i2cme_checker u_i2cme_checker (.*);

`default_nettype wire
